// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checks in the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lbmc_pkg.sv =====
// Shared types and codes for the lock-box mode controller.
package lbmc_pkg;

    // Storage and code widths
    localparam int LBMC_FLAG_SLOTS = 8;
    localparam int CODE_W          = 4;
    localparam int FLAG_CODES      = 1 << CODE_W;

    // Request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_STEP   = 2'd1;
    localparam logic [1:0] REQ_TIMER  = 2'd2;

    // Lock actions
    localparam logic [1:0] LOCK_NONE    = 2'd0;
    localparam logic [1:0] LOCK_ENGAGE  = 2'd1;
    localparam logic [1:0] LOCK_RELEASE = 2'd2;

    // Mode codes
    localparam logic [CODE_W-1:0] MODE_U_EMPTY_ASLEEP = 4'd0;
    localparam logic [CODE_W-1:0] MODE_U_WAKING       = 4'd1;
    localparam logic [CODE_W-1:0] MODE_U_EMPTY_AWAKE  = 4'd2;
    localparam logic [CODE_W-1:0] MODE_U_FULL_AWAKE_A = 4'd3;
    localparam logic [CODE_W-1:0] MODE_U_FULL_AWAKE_B = 4'd4;
    localparam logic [CODE_W-1:0] MODE_U_FULL_ASLEEP  = 4'd5;
    localparam logic [CODE_W-1:0] MODE_U_TO_LOCKED    = 4'd6;
    localparam logic [CODE_W-1:0] MODE_L_FULL_AWAKE   = 4'd7;
    localparam logic [CODE_W-1:0] MODE_L_NOTIFY_A     = 4'd8;
    localparam logic [CODE_W-1:0] MODE_L_NOTIFY_B     = 4'd9;
    localparam logic [CODE_W-1:0] MODE_L_FULL_ASLEEP  = 4'd10;
    localparam logic [CODE_W-1:0] MODE_L_MON_AWAKE    = 4'd11;
    localparam logic [CODE_W-1:0] MODE_L_MON_ASLEEP   = 4'd12;
    localparam logic [CODE_W-1:0] MODE_EMERGENCY_OPEN = 4'd13;

    // Flag codes (bit positions in the present mask)
    localparam int FLAG_MOVED      = 1;
    localparam int FLAG_KNOB_PRESS = 4;
    localparam int FLAG_KNOB_TURN  = 5;
    localparam int FLAG_TIMER      = 6;
    localparam int FLAG_PHONE_IN   = 7;
    localparam int FLAG_PHONE_OUT  = 8;
    localparam int FLAG_BOX_CLOSED = 9;
    localparam int FLAG_BOX_OPEN   = 10;
    localparam int FLAG_AUDIO_LOUD = 11;
    localparam int FLAG_AUDIO_HIT  = 12;
    localparam int FLAG_AUDIO_MISS = 13;

    // Per-mode interrupt enables, one bit per mode code
    localparam logic [FLAG_CODES-1:0] BUTTON_EN_MODES = 16'h0775;
    localparam logic [FLAG_CODES-1:0] AUDIO_EN_MODES  = 16'h1C80;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CODE_W-1:0] flag_code;
    } lbmc_in_t;

    typedef struct packed {
        logic              insert_ok;
        logic [CODE_W-1:0] box_state;
        logic [CODE_W-1:0] prior_state;
        logic              changed;
        logic [1:0]        lock_action;
        logic              button_irq_en;
        logic              audio_irq_en;
    } lbmc_out_t;

    // Flag set control from the top level
    typedef struct packed {
        logic              insert;
        logic              clear;
        logic [CODE_W-1:0] code;
    } lbmc_flag_ctrl_t;

    // Transition decision for one step
    typedef struct packed {
        logic [CODE_W-1:0] next_mode;
        logic              changed;
        logic [1:0]        lock_action;
        logic              button_en;
        logic              audio_en;
    } lbmc_mode_res_t;

endpackage

// ===== hw/rtl/lbmc_flag_set.sv =====
// Event flag set: slot storage, insert with duplicate check, clear, present mask.
module lbmc_flag_set import lbmc_pkg::*; #(
    parameter int FLAG_SLOTS = LBMC_FLAG_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lbmc_flag_ctrl_t       ctrl,
    output logic                  insert_ok,
    output logic [FLAG_CODES-1:0] present
);

    logic [CODE_W-1:0]     slot_reg [FLAG_SLOTS];
    logic [FLAG_SLOTS-1:0] wr_sel;
    logic                  match;
    logic                  empty_seen;
    logic [FLAG_CODES-1:0] mask;

    // Parallel compare against all slots, pick the first empty one
    always_comb begin
        match      = 1'b0;
        empty_seen = 1'b0;
        wr_sel     = '0;
        for (int i = 0; i < FLAG_SLOTS; i++) begin
            if (slot_reg[i] == ctrl.code) begin
                match = 1'b1;
            end
            if (slot_reg[i] == '0) begin
                wr_sel[i]  = !empty_seen;
                empty_seen = 1'b1;
            end
        end
        insert_ok = !match && empty_seen;
    end

    // Present mask, code zero means empty
    always_comb begin
        mask = '0;
        for (int i = 0; i < FLAG_SLOTS; i++) begin
            mask[slot_reg[i]] = 1'b1;
        end
        present = mask & ~FLAG_CODES'(1);
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        for (int i = 0; i < FLAG_SLOTS; i++) begin
            if (!aresetn || ctrl.clear) begin
                slot_reg[i] <= '0;
            end else if (ctrl.insert && insert_ok && wr_sel[i]) begin
                slot_reg[i] <= ctrl.code;
            end
        end
    end

endmodule

// ===== hw/rtl/lbmc_mode_logic.sv =====
// Prioritized next-mode table, override, lock action and interrupt enables.
module lbmc_mode_logic import lbmc_pkg::*; (
    input  logic [CODE_W-1:0]     cur_mode,
    input  logic [FLAG_CODES-1:0] fm,
    input  logic                  override,
    output lbmc_mode_res_t        res
);

    logic [CODE_W-1:0] tbl_mode;
    logic [CODE_W-1:0] nxt;

    // Transition table, first matching row wins
    always_comb begin
        tbl_mode = cur_mode;
        case (cur_mode)
            MODE_U_EMPTY_ASLEEP: begin
                if (fm[FLAG_MOVED] || fm[FLAG_KNOB_PRESS] || fm[FLAG_KNOB_TURN])
                    tbl_mode = MODE_U_WAKING;
            end
            MODE_U_WAKING: begin
                if (fm[FLAG_TIMER]) tbl_mode = MODE_U_EMPTY_AWAKE;
            end
            MODE_U_EMPTY_AWAKE: begin
                if (fm[FLAG_PHONE_IN]) tbl_mode = MODE_U_FULL_AWAKE_A;
                else if (fm[FLAG_TIMER] || fm[FLAG_KNOB_PRESS])
                    tbl_mode = MODE_U_EMPTY_ASLEEP;
            end
            MODE_U_FULL_AWAKE_A: begin
                if (fm[FLAG_PHONE_OUT]) tbl_mode = MODE_U_EMPTY_AWAKE;
                else if (fm[FLAG_KNOB_TURN]) tbl_mode = MODE_U_FULL_AWAKE_B;
                else if (fm[FLAG_TIMER] || fm[FLAG_KNOB_PRESS])
                    tbl_mode = MODE_U_FULL_ASLEEP;
            end
            MODE_U_FULL_AWAKE_B: begin
                if (fm[FLAG_KNOB_PRESS] && fm[FLAG_BOX_CLOSED])
                    tbl_mode = MODE_U_TO_LOCKED;
                else if (fm[FLAG_KNOB_TURN]) tbl_mode = MODE_U_FULL_AWAKE_A;
                else if (fm[FLAG_PHONE_OUT]) tbl_mode = MODE_U_EMPTY_AWAKE;
                else if (fm[FLAG_TIMER]) tbl_mode = MODE_U_FULL_ASLEEP;
            end
            MODE_U_FULL_ASLEEP: begin
                if (fm[FLAG_PHONE_OUT]) tbl_mode = MODE_U_EMPTY_AWAKE;
                else if (fm[FLAG_MOVED] || fm[FLAG_KNOB_TURN] || fm[FLAG_KNOB_PRESS])
                    tbl_mode = MODE_U_FULL_AWAKE_A;
            end
            MODE_U_TO_LOCKED: begin
                if (fm[FLAG_PHONE_OUT] || fm[FLAG_BOX_OPEN] || fm[FLAG_KNOB_PRESS])
                    tbl_mode = MODE_U_FULL_AWAKE_B;
                else if (fm[FLAG_TIMER]) tbl_mode = MODE_L_FULL_AWAKE;
            end
            MODE_L_FULL_AWAKE: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_TIMER]) tbl_mode = MODE_L_FULL_ASLEEP;
                else if (fm[FLAG_AUDIO_LOUD]) tbl_mode = MODE_L_MON_AWAKE;
            end
            MODE_L_NOTIFY_A: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_KNOB_PRESS]) tbl_mode = MODE_U_FULL_AWAKE_B;
                else if (fm[FLAG_KNOB_TURN]) tbl_mode = MODE_L_NOTIFY_B;
                else if (fm[FLAG_TIMER]) tbl_mode = MODE_L_FULL_AWAKE;
            end
            MODE_L_NOTIFY_B: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_KNOB_TURN]) tbl_mode = MODE_L_NOTIFY_A;
                else if (fm[FLAG_TIMER]) tbl_mode = MODE_L_FULL_AWAKE;
            end
            MODE_L_FULL_ASLEEP: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_AUDIO_LOUD]) tbl_mode = MODE_L_MON_ASLEEP;
                else if (fm[FLAG_KNOB_PRESS] || fm[FLAG_KNOB_TURN] || fm[FLAG_MOVED])
                    tbl_mode = MODE_L_FULL_AWAKE;
            end
            MODE_L_MON_AWAKE: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_AUDIO_HIT]) tbl_mode = MODE_L_NOTIFY_B;
                else if (fm[FLAG_AUDIO_MISS]) tbl_mode = MODE_L_FULL_AWAKE;
            end
            MODE_L_MON_ASLEEP: begin
                if (fm[FLAG_BOX_OPEN]) tbl_mode = MODE_EMERGENCY_OPEN;
                else if (fm[FLAG_AUDIO_HIT]) tbl_mode = MODE_L_NOTIFY_B;
                else if (fm[FLAG_AUDIO_MISS]) tbl_mode = MODE_L_FULL_ASLEEP;
            end
            MODE_EMERGENCY_OPEN: begin
                if (fm[FLAG_TIMER]) tbl_mode = MODE_U_FULL_AWAKE_B;
            end
            default: tbl_mode = cur_mode;
        endcase
    end

    // Override, change detect, lock action, enables for the new mode
    always_comb begin
        nxt = override ? MODE_U_FULL_AWAKE_A : tbl_mode;
        res.next_mode   = nxt;
        res.changed     = (nxt != cur_mode);
        res.lock_action = LOCK_NONE;
        if (res.changed) begin
            if (cur_mode == MODE_U_TO_LOCKED && nxt == MODE_L_FULL_AWAKE)
                res.lock_action = LOCK_ENGAGE;
            else if ((cur_mode == MODE_L_FULL_AWAKE || cur_mode == MODE_L_FULL_ASLEEP)
                     && nxt == MODE_U_FULL_AWAKE_B)
                res.lock_action = LOCK_RELEASE;
            else if (nxt == MODE_EMERGENCY_OPEN)
                res.lock_action = LOCK_RELEASE;
        end
        res.button_en = BUTTON_EN_MODES[nxt];
        res.audio_en  = AUDIO_EN_MODES[nxt];
    end

endmodule

// ===== hw/rtl/lock_box_mode_controller_unit.sv =====
// Lock-box mode controller top level: input register, state update, result register.
//
// Usage: each input word carries a request (insert flag, step, master timer done)
// and a flag code; each accepted word yields exactly one result word.
// Channels: s_valid/s_ready/s_data in, m_valid/m_ready/m_data out, both valid/ready.
// Flow: an accepted word is loaded into the input register; its result is written
// to the output register once it is empty or drained; m_data shows it from then on.
// Throughput: one word per cycle while m_ready is high. The limit is the state loop:
// slot compare, present mask and next-mode table are all combinational from the mode
// and flag registers.
// Reset (aresetn low, synchronous): mode, last mode, all flag slots, the pending
// override and both interrupt enables clear; both pipeline registers go empty.
// Stall: while m_ready is low a held result blocks the input register, which still
// takes one more word, after which s_ready drops until the result is taken.
`include "assert_macros.svh"

module lock_box_mode_controller_unit import lbmc_pkg::*; #(
    parameter int FLAG_SLOTS = LBMC_FLAG_SLOTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  lbmc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lbmc_out_t m_data
);

    logic                  in_valid_reg;
    lbmc_in_t              in_data_reg;
    logic                  out_valid_reg;
    lbmc_out_t             out_data_reg;
    lbmc_out_t             out_data_next;
    logic [CODE_W-1:0]     mode_reg, mode_next;
    logic [CODE_W-1:0]     last_mode_reg, last_mode_next;
    logic                  override_reg, override_next;
    logic                  button_reg, button_next;
    logic                  audio_reg, audio_next;

    logic                  proc_fire;
    logic                  is_insert, is_step, is_timer;
    logic                  step_change;
    lbmc_flag_ctrl_t       flag_ctrl;
    logic                  flag_insert_ok;
    logic [FLAG_CODES-1:0] flag_present;
    lbmc_mode_res_t        mode_res;

    // Handshake
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Request decode
    assign is_insert   = (in_data_reg.req_type == REQ_INSERT);
    assign is_step     = (in_data_reg.req_type == REQ_STEP);
    assign is_timer    = (in_data_reg.req_type == REQ_TIMER);
    assign step_change = is_step && mode_res.changed;

    assign flag_ctrl.insert = proc_fire && is_insert;
    assign flag_ctrl.clear  = proc_fire && step_change;
    assign flag_ctrl.code   = in_data_reg.flag_code;

    lbmc_flag_set #(
        .FLAG_SLOTS (FLAG_SLOTS)
    ) u_flag_set (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (flag_ctrl),
        .insert_ok (flag_insert_ok),
        .present   (flag_present)
    );

    lbmc_mode_logic u_mode_logic (
        .cur_mode (mode_reg),
        .fm       (flag_present),
        .override (override_reg),
        .res      (mode_res)
    );

    // Next state and result word
    always_comb begin
        mode_next      = step_change ? mode_res.next_mode : mode_reg;
        last_mode_next = step_change ? mode_reg : last_mode_reg;
        button_next    = step_change ? mode_res.button_en : button_reg;
        audio_next     = step_change ? mode_res.audio_en : audio_reg;
        override_next  = override_reg;
        if (is_timer) begin
            override_next = 1'b1;
        end else if (is_step) begin
            override_next = 1'b0;
        end
        out_data_next.insert_ok     = is_insert && flag_insert_ok;
        out_data_next.box_state     = mode_next;
        out_data_next.prior_state   = last_mode_next;
        out_data_next.changed       = step_change;
        out_data_next.lock_action   = step_change ? mode_res.lock_action : LOCK_NONE;
        out_data_next.button_irq_en = button_next;
        out_data_next.audio_irq_en  = audio_next;
    end

    // Pipeline and mode registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_U_EMPTY_ASLEEP;
            last_mode_reg <= MODE_U_EMPTY_ASLEEP;
            override_reg  <= 1'b0;
            button_reg    <= 1'b0;
            audio_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                last_mode_reg <= last_mode_next;
                override_reg  <= override_next;
                button_reg    <= button_next;
                audio_reg     <= audio_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks
    `LBMC_ASSERT_IMPL(a_change_moves, aclk, aresetn, m_valid && m_data.changed, m_data.box_state != m_data.prior_state, "changed result keeps the same mode")
    `LBMC_ASSERT_IMPL(a_action_on_change, aclk, aresetn, m_valid && (m_data.lock_action != LOCK_NONE), m_data.changed, "lock action without a mode change")
    `LBMC_ASSERT_IMPL(a_insert_no_change, aclk, aresetn, m_valid && m_data.insert_ok, !m_data.changed && (m_data.lock_action == LOCK_NONE), "insert result reports a mode change")
    `LBMC_ASSERT_NEXT(a_flags_cleared, aclk, aresetn, proc_fire && step_change, flag_present == '0, "flags not cleared after a mode change")

endmodule
